// ----- rtl/ddm_pkg.sv -----
// ---------------------------------------------------------------------------
// ddm_pkg: shared constants and table function
// Widths, register indexes and reset values for the drive mixer, plus the
// constant function that builds the power-curve table.
// ---------------------------------------------------------------------------
package ddm_pkg;

  localparam int HIST_DEPTH_DEF = 10;
  localparam int TAB_DEPTH_DEF  = 256;

  localparam int TAB_W   = 21;  // table entries of deepest table fit here
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 24;  // also holds the history-average reciprocal
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd4;

  localparam logic [14:0] MIN_POWER_RST = 15'd3277;
  localparam logic [14:0] BRAKE_THR_RST = 15'd2048;
  localparam logic [14:0] MAX_SPEED_RST = 15'd6472;
  localparam logic [14:0] TURN_GAIN_RST = 15'd1024;
  localparam logic [12:0] DEADBAND_RST  = 13'd41;

  // true when x^5 <= m
  function automatic logic fifth_fits(logic [63:0] x, logic [63:0] m);
    logic [127:0] p;
    logic         ok;
    p  = 128'd1;
    ok = 1'b1;
    if (x != 64'd0) begin
      for (int k = 0; k < 5; k++) begin
        p = p * {64'd0, x};
        if (p > {64'd0, m}) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // entry i ~ ((n/32)^1.6)*4096, n = 32 + i
  function automatic logic [TAB_W-1:0] pow_entry(int i);
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] e;
    n  = 64'(32 + i);
    m  = (n * n * n) << 30;
    lo = 64'd0;
    hi = 64'd8192;
    while (hi - lo > 64'd1) begin
      mid = (lo + hi) >> 1;
      if (fifth_fits(mid, m)) lo = mid;
      else hi = mid;
    end
    e = (n * lo) >> 2;
    return e[TAB_W-1:0];
  endfunction

endpackage

// ----- rtl/ddm_mul.sv -----
// ---------------------------------------------------------------------------
// ddm_mul: shared multiplier
// Unsigned multiply with the product registered.
// ---------------------------------------------------------------------------
module ddm_mul (
  input  logic                        clk,
  input  logic [ddm_pkg::MUL_A_W-1:0] a,
  input  logic [ddm_pkg::MUL_B_W-1:0] b,
  output logic [ddm_pkg::MUL_P_W-1:0] prod
);
  import ddm_pkg::*;

  logic [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign prod = prod_r;

endmodule

// ----- rtl/ddm_div.sv -----
// ---------------------------------------------------------------------------
// ddm_div: serial divider
// Restoring unsigned divide, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ddm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ddm_pkg::DIV_N_W-1:0] dividend,
  input  logic [ddm_pkg::DIV_D_W-1:0] divisor,
  output logic                        done,
  output logic [ddm_pkg::DIV_N_W-1:0] quo
);
  import ddm_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] dsr_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W:0]   sh;
  logic [DIV_D_W+1:0] trial;
  logic               ge;

  assign sh    = {rem_r, quo_r[DIV_N_W-1]};
  assign trial = {1'b0, sh} - {2'b0, dsr_r};
  assign ge    = !trial[DIV_D_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial[DIV_D_W-1:0] : sh[DIV_D_W-1:0];
      quo_r <= {quo_r[DIV_N_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/ddm_hist.sv -----
// ---------------------------------------------------------------------------
// ddm_hist: speed history
// Ring of past effective speeds with a running sum.
// ---------------------------------------------------------------------------
module ddm_hist #(
  parameter int DEPTH = ddm_pkg::HIST_DEPTH_DEF,
  parameter int SUM_W = 17 + $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd,
  input  logic signed [15:0]      wr_data,
  output logic signed [SUM_W-1:0] sum
);
  import ddm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [15:0]      mem [DEPTH];
  logic signed [15:0]      rd_r;
  logic [DEPTH-1:0]        vld_r;
  logic [PTR_W-1:0]        ptr_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [15:0]      old;

  always_ff @(posedge clk) begin
    rd_r <= mem[ptr_r];
    if (upd) mem[ptr_r] <= wr_data;
  end

  // never-written slots read as zero
  assign old = vld_r[ptr_r] ? rd_r : 16'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ptr_r <= '0;
      sum_r <= '0;
    end else if (upd) begin
      vld_r[ptr_r] <= 1'b1;
      ptr_r <= (ptr_r == PTR_W'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
      sum_r <= sum_r + SUM_W'(wr_data) - SUM_W'(old);
    end
  end

  assign sum = sum_r;

endmodule

// ----- rtl/differential_drive_mixer_with_braking_unit.sv -----
// one word at a time; the long path runs two rescale and two power-map serial divisions;
// both wheels skip the rescale when neither exceeds the speed limit, and a wheel inside
// the deadband skips its division
// the next word is taken the cycle after the result loads
// a result not yet taken holds the block in S_OUT, and the next word is not accepted
// reset (rst_n low, synchronous) restores configuration registers and state, clears history and sum
// ---------------------------------------------------------------------------
// differential_drive_mixer_with_braking_unit: drive mixer top level
// Mixes speed and turn into wheel power with active braking, using one
// shared multiplier and one serial divider under a small sequencer.
// ---------------------------------------------------------------------------
module differential_drive_mixer_with_braking_unit #(
  parameter int HISTORY_DEPTH    = ddm_pkg::HIST_DEPTH_DEF,
  parameter int TURN_TABLE_DEPTH = ddm_pkg::TAB_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             in_speed_cmd,
  input  logic signed [15:0]             in_turn_cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_left_power,
  output logic signed [15:0]             out_right_power,
  output logic                           out_braked,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ddm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ddm_pkg::*;

  localparam int SUM_W = 17 + $clog2(HISTORY_DEPTH);
  localparam int IDX_W = $clog2(TURN_TABLE_DEPTH);
  // history average by reciprocal multiply, exact for any sum magnitude
  localparam int     AVG_K   = (SUM_W - 1) + $clog2(HISTORY_DEPTH);
  localparam longint AVG_RCP = ((longint'(1) << AVG_K) + longint'(HISTORY_DEPTH) - 1) /
                               longint'(HISTORY_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_AVG, S_AVG_HI, S_AVG_SUM, S_BRAKE, S_MUL0, S_MUL1, S_MUL2, S_MUL3,
    S_MIX, S_SCALE_MUL, S_SCALE_DIV, S_SCALE_WAIT, S_PWR_MUL, S_PWR_DIV,
    S_PWR_WAIT, S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [14:0] min_power_r;
  logic [14:0] brake_thr_r;
  logic [14:0] max_speed_r;
  logic [14:0] turn_gain_r;
  logic [12:0] deadband_r;

  // per-word working registers
  logic signed [15:0] speed_r;
  logic signed [15:0] turn_r;
  logic signed [15:0] prev_r;
  logic               braked_r;
  logic signed [17:0] avg_r;
  logic [13:0]        hi_r;
  logic [MUL_P_W-1:0] acc_r;
  logic signed [16:0] delta_r;
  logic signed [17:0] wheel_r [2];
  logic [15:0]        e_r;
  logic               w_r;
  logic signed [15:0] pw_r [2];

  // result register
  logic               out_valid_r;
  logic signed [15:0] out_left_r;
  logic signed [15:0] out_right_r;
  logic               out_braked_r;
  logic               out_load;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic               div_start;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;

  logic                    hist_upd;
  logic signed [SUM_W-1:0] hist_sum;

  // power-curve table, built at elaboration
  logic [TAB_W-1:0] pow_tab [TURN_TABLE_DEPTH];
  for (genvar g = 0; g < TURN_TABLE_DEPTH; g++) begin : g_tab
    assign pow_tab[g] = pow_entry(g);
  end

  logic [14:0]        ms;
  logic [16:0]        spd_abs;
  logic [16:0]        turn_abs;
  logic [9:0]         a7;
  logic [IDX_W-1:0]   tab_idx;
  logic [TAB_W-1:0]   tab_val;
  logic [SUM_W-1:0]   sum_abs;
  logic [47:0]        avg_full;
  logic [15:0]        avg_q;
  logic signed [17:0] avg_nxt;
  logic signed [18:0] brk_diff;
  logic signed [18:0] brk_val;
  logic               brk_hit;
  logic signed [15:0] brk_sat;
  logic [51:0]        full;
  logic [27:0]        dmag;
  logic [14:0]        dmag_c;
  logic signed [16:0] delta_nxt;
  logic signed [17:0] right_nxt;
  logic signed [17:0] left_nxt;
  logic [16:0]        ar;
  logic [16:0]        al;
  logic signed [17:0] wsel;
  logic [16:0]        wabs;
  logic signed [17:0] wscaled;
  logic signed [16:0] prange;
  logic [14:0]        prange_abs;
  logic               pzero;
  logic signed [18:0] pq;
  logic signed [18:0] pval;
  logic signed [15:0] psat;

  assign ms       = (max_speed_r == '0) ? 15'd1 : max_speed_r;
  assign spd_abs  = speed_r[15] ? 17'(-17'(speed_r)) : 17'(speed_r);
  assign turn_abs = turn_r[15] ? 17'(-17'(turn_r)) : 17'(turn_r);

  // table index saturates at the last entry
  assign a7      = spd_abs[16:7];
  assign tab_idx = (a7 > 10'(TURN_TABLE_DEPTH - 1)) ? IDX_W'(TURN_TABLE_DEPTH - 1)
                                                    : a7[IDX_W-1:0];
  assign tab_val = pow_tab[tab_idx];

  // average: |sum| times the reciprocal in two partial products, sign put back
  assign sum_abs  = hist_sum[SUM_W-1] ? SUM_W'(-hist_sum) : SUM_W'(hist_sum);
  assign avg_full = 48'(acc_r) + (48'(prod) << 16);
  assign avg_q    = avg_full[AVG_K+15:AVG_K];
  assign avg_nxt  = hist_sum[SUM_W-1] ? -$signed({2'b0, avg_q}) : $signed({2'b0, avg_q});

  // braking
  assign brk_diff = 19'(avg_r) - 19'(speed_r);
  assign brk_hit  = (brk_diff > $signed({4'b0, brake_thr_r})) && (avg_r > 18'sd0);
  assign brk_val  = (19'(speed_r) <<< 1) - 19'(avg_r);
  assign brk_sat  = (brk_val > 19'sd32767)  ? 16'sh7fff :
                    (brk_val < -19'sd32768) ? 16'sh8000 : brk_val[15:0];

  // turn delta: two partial products, truncated toward zero, clamped
  assign full      = 52'(acc_r) + (52'(prod) << 16);
  assign dmag      = full[51:24];
  assign dmag_c    = (dmag > 28'(ms)) ? ms : dmag[14:0];
  assign delta_nxt = turn_r[15] ? -$signed({2'b0, dmag_c}) : $signed({2'b0, dmag_c});

  assign right_nxt = 18'(speed_r) + 18'(delta_r);
  assign left_nxt  = 18'(speed_r) - 18'(delta_r);
  assign ar        = right_nxt[17] ? 17'(-right_nxt) : 17'(right_nxt);
  assign al        = left_nxt[17] ? 17'(-left_nxt) : 17'(left_nxt);

  // current wheel
  assign wsel    = wheel_r[w_r];
  assign wabs    = wsel[17] ? 17'(-wsel) : 17'(wsel);
  assign wscaled = wsel[17] ? -$signed({3'b0, div_q[14:0]}) : $signed({3'b0, div_q[14:0]});

  // power mapping
  assign prange     = 17'sd16384 - $signed({2'b0, min_power_r});
  assign prange_abs = prange[16] ? 15'(-prange) : 15'(prange);
  assign pzero      = (wsel == 18'sd0) || (wabs < 17'(deadband_r));
  assign pq         = (prange[16] ^ wsel[17]) ? -$signed({3'b0, div_q[15:0]})
                                              : $signed({3'b0, div_q[15:0]});
  assign pval       = pq + (wsel[17] ? -$signed({4'b0, min_power_r})
                                     : $signed({4'b0, min_power_r}));
  assign psat       = (pval > 19'sd16384)  ? 16'sd16384 :
                      (pval < -19'sd16384) ? -16'sd16384 : pval[15:0];

  // result register loads when the previous word is gone or leaving
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // shared unit operand selection
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (state_r)
      S_AVG: begin
        mul_a = MUL_A_W'(sum_abs[15:0]);
        mul_b = MUL_B_W'(AVG_RCP);
      end
      S_AVG_HI: begin
        mul_a = MUL_A_W'(sum_abs[SUM_W-1:16]);
        mul_b = MUL_B_W'(AVG_RCP);
      end
      S_MUL0: begin
        mul_a = turn_abs;
        mul_b = MUL_B_W'(turn_gain_r);
      end
      S_MUL1: begin
        mul_a = MUL_A_W'(prod[15:0]);
        mul_b = MUL_B_W'(tab_val);
      end
      S_MUL2: begin
        mul_a = MUL_A_W'(hi_r);
        mul_b = MUL_B_W'(tab_val);
      end
      S_SCALE_MUL: begin
        mul_a = wabs;
        mul_b = MUL_B_W'(ms);
      end
      S_SCALE_DIV: begin
        div_start = 1'b1;
        div_n     = prod[DIV_N_W-1:0];
        div_d     = e_r;
      end
      S_PWR_MUL: begin
        mul_a = wabs;
        mul_b = MUL_B_W'(prange_abs);
      end
      S_PWR_DIV: begin
        div_start = 1'b1;
        div_n     = prod[DIV_N_W-1:0];
        div_d     = DIV_D_W'(ms);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign hist_upd = (state_r == S_IDLE) && in_valid;

  // sequencer, working registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      min_power_r <= MIN_POWER_RST;
      brake_thr_r <= BRAKE_THR_RST;
      max_speed_r <= MAX_SPEED_RST;
      turn_gain_r <= TURN_GAIN_RST;
      deadband_r  <= DEADBAND_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_POWER: min_power_r <= cfg_data[14:0];
          REG_BRAKE_THR: brake_thr_r <= cfg_data[14:0];
          REG_MAX_SPEED: max_speed_r <= cfg_data[14:0];
          REG_TURN_GAIN: turn_gain_r <= cfg_data[14:0];
          REG_DEADBAND:  deadband_r  <= cfg_data[12:0];
          default:       ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            speed_r <= in_speed_cmd;
            turn_r  <= in_turn_cmd;
            state_r <= S_AVG;
          end
        end
        S_AVG: state_r <= S_AVG_HI;
        S_AVG_HI: begin
          acc_r   <= prod;
          state_r <= S_AVG_SUM;
        end
        S_AVG_SUM: begin
          avg_r   <= avg_nxt;
          state_r <= S_BRAKE;
        end
        S_BRAKE: begin
          braked_r <= brk_hit;
          if (brk_hit) begin
            speed_r <= brk_sat;
            prev_r  <= brk_sat;
          end else begin
            prev_r  <= speed_r;
          end
          state_r <= S_MUL0;
        end
        S_MUL0: state_r <= S_MUL1;
        S_MUL1: begin
          hi_r    <= prod[29:16];
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          acc_r   <= prod;
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          delta_r <= delta_nxt;
          state_r <= S_MIX;
        end
        S_MIX: begin
          wheel_r[0] <= left_nxt;
          wheel_r[1] <= right_nxt;
          w_r        <= 1'b0;
          e_r        <= (ar > al) ? ar[15:0] : al[15:0];
          // rescale both sides only when one exceeds the limit
          if (ar > 17'(ms) || al > 17'(ms)) state_r <= S_SCALE_MUL;
          else state_r <= S_PWR_MUL;
        end
        S_SCALE_MUL: state_r <= S_SCALE_DIV;
        S_SCALE_DIV: state_r <= S_SCALE_WAIT;
        S_SCALE_WAIT: begin
          if (div_done) begin
            wheel_r[w_r] <= wscaled;
            w_r          <= ~w_r;
            state_r      <= w_r ? S_PWR_MUL : S_SCALE_MUL;
          end
        end
        S_PWR_MUL: begin
          if (pzero) begin
            pw_r[w_r] <= '0;
            w_r       <= ~w_r;
            state_r   <= w_r ? S_OUT : S_PWR_MUL;
          end else begin
            state_r <= S_PWR_DIV;
          end
        end
        S_PWR_DIV: state_r <= S_PWR_WAIT;
        S_PWR_WAIT: begin
          if (div_done) begin
            pw_r[w_r] <= psat;
            w_r       <= ~w_r;
            state_r   <= w_r ? S_OUT : S_PWR_MUL;
          end
        end
        S_OUT: begin
          // hold until the result register is free
          if (out_load) begin
            out_left_r   <= pw_r[0];
            out_right_r  <= pw_r[1];
            out_braked_r <= braked_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ddm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ddm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_q)
  );

  ddm_hist #(
    .DEPTH (HISTORY_DEPTH),
    .SUM_W (SUM_W)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (hist_upd),
    .wr_data (prev_r),
    .sum     (hist_sum)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_left_power  = out_left_r;
  assign out_right_power = out_right_r;
  assign out_braked      = out_braked_r;

endmodule

// ----- tb/tb_differential_drive_mixer_with_braking_unit.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_differential_drive_mixer_with_braking_unit: drive mixer testbench
// Drives speed/turn words through the mixer under random idling and
// backpressure, predicts wheel power and braking with a local model of the
// mixer, and compares every result word field by field.
// ---------------------------------------------------------------------------
module tb_differential_drive_mixer_with_braking_unit;
  import ddm_pkg::*;

  localparam int HDEPTH = 10;
  localparam int TDEPTH = 256;
  localparam int RANDOM_WORDS = 1950;
  localparam int EXP_DEPTH = 4096;
  localparam int ROW_DEPTH = 64;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_speed_cmd = '0;
  logic signed [15:0] in_turn_cmd = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_left_power;
  logic signed [15:0] out_right_power;
  logic out_braked;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  differential_drive_mixer_with_braking_unit u_top (.*);

  always #1 clk = ~clk;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               braked;
  } power_word_t;

  // typed-in expectation: chk set means the model's prediction for that row is also compared with it
  typedef struct {
    logic signed [15:0] speed;
    logic signed [15:0] turn;
    logic               chk;
    power_word_t        want;
  } drive_row_t;

  // mixer state mirrored here
  int unsigned mp, thr, msp, gain, db;
  int hist [HDEPTH];
  int hsum, hptr, prev_speed;
  int curve [TDEPTH];

  // expected words in order, written at input accept, read at result accept
  power_word_t expected_power [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int mismatches = 0;
  int results_seen = 0;
  bit idle_free = 1'b0;   // stretch with no idling on either side
  bit hold_off = 1'b0;    // receiver long stall

  // power-curve table, computed independently by integer fifth root
  function automatic longint root5(longint m);
    longint lo, hi, mid, p;
    bit ok;
    lo = 0; hi = 8192;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      p = 1; ok = 1;
      for (int k = 0; k < 5; k++) begin
        if (mid != 0 && p > m / mid) ok = 0;
        else p = p * mid;
      end
      if (ok) lo = mid; else hi = mid;
    end
    return lo;
  endfunction

  function automatic void reset_mirror();
    mp = MIN_POWER_RST; thr = BRAKE_THR_RST; msp = MAX_SPEED_RST;
    gain = TURN_GAIN_RST; db = DEADBAND_RST;
    foreach (hist[i]) hist[i] = 0;
    hsum = 0; hptr = 0; prev_speed = 0;
  endfunction

  function automatic logic signed [15:0] wheel_to_power(int s, int ms);
    longint a, p;
    a = s < 0 ? -s : s;
    if (s == 0 || a < db) return 16'sd0;
    p = ((16384 - longint'(mp)) * s) / ms;
    p += (s > 0) ? longint'(mp) : -longint'(mp);
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    return 16'(p);
  endfunction

  function automatic power_word_t mix_drive(logic signed [15:0] sc, logic signed [15:0] tc);
    power_word_t r;
    int sp, avg, b, ms, a, idx, lw, rw, al, ar, e;
    longint d;
    sp = sc;
    hsum += prev_speed - hist[hptr];
    hist[hptr] = prev_speed;
    hptr = (hptr + 1) % HDEPTH;
    avg = hsum / HDEPTH;
    r.braked = 1'b0;
    if (avg - sp > int'(thr) && avg > 0) begin
      b = 2 * sp - avg;
      if (b > 32767) b = 32767;
      if (b < -32768) b = -32768;
      sp = b;
      r.braked = 1'b1;
    end
    prev_speed = sp;
    ms = msp == 0 ? 1 : int'(msp);
    a = sp < 0 ? -sp : sp;
    idx = a >> 7;
    if (idx > TDEPTH - 1) idx = TDEPTH - 1;
    d = (longint'(tc) * longint'(gain) * longint'(curve[idx])) / (longint'(1) << 24);
    if (d > ms) d = ms;
    if (d < -ms) d = -ms;
    rw = sp + int'(d);
    lw = sp - int'(d);
    ar = rw < 0 ? -rw : rw;
    al = lw < 0 ? -lw : lw;
    if (ar > ms || al > ms) begin
      e = ar > al ? ar : al;
      rw = int'((longint'(rw) * ms) / e);
      lw = int'((longint'(lw) * ms) / e);
    end
    r.left = wheel_to_power(lw, ms);
    r.right = wheel_to_power(rw, ms);
    return r;
  endfunction

  // valid drops only while idling, so it is never driven twice in one step
  task automatic idle_gap();
    while (!idle_free && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_word(logic signed [15:0] sc, logic signed [15:0] tc);
    idle_gap();
    in_valid <= 1'b1;
    in_speed_cmd <= sc;
    in_turn_cmd <= tc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_power[exp_wr % EXP_DEPTH] = mix_drive(sc, tc);
    exp_wr++;
  endtask

  // drain, then leave room for a word still in flight
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ix, int unsigned v);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= CFG_DATA_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ix)
      REG_MIN_POWER: mp = v & 16'h7fff;
      REG_BRAKE_THR: thr = v & 16'h7fff;
      REG_MAX_SPEED: msp = v & 16'h7fff;
      REG_TURN_GAIN: gain = v & 16'h7fff;
      REG_DEADBAND:  db = v & 16'h1fff;
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned a0, int unsigned a1, int unsigned a2,
                           int unsigned a3, int unsigned a4);
    write_reg(REG_MIN_POWER, a0);
    write_reg(REG_BRAKE_THR, a1);
    write_reg(REG_MAX_SPEED, a2);
    write_reg(REG_TURN_GAIN, a3);
    write_reg(REG_DEADBAND, a4);
    cfg_valid <= 1'b0;
  endtask

  // random jumps, sign flips and upward ramps so the history average triggers braking
  task automatic random_phase(int words);
    int level;
    level = 0;
    for (int k = 0; k < words; k++) begin
      case ($urandom_range(9))
        0, 1: level = $signed(16'($urandom));
        2, 3, 4: level = $signed(16'($urandom_range(4000, 20000)));
        5: level = -level;
        default: level = level + $signed(16'($urandom_range(0, 4000))) - 1000;
      endcase
      if (level > 32767) level = 32767;
      if (level < -32768) level = -32768;
      if ($urandom_range(3) == 0)
        send_word(16'(level), $signed(16'($urandom)));
      else
        send_word(16'(level), 16'($signed($urandom_range(0, 4000)) - 2000));
    end
  endtask

  // receiver: random stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= idle_free || ($urandom_range(99) >= 28);
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    power_word_t w;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (exp_wr == exp_rd) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result word l=%0d r=%0d b=%0d",
          out_left_power, out_right_power, out_braked);
      end else begin
        w = expected_power[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (w.left !== out_left_power || w.right !== out_right_power ||
            w.braked !== out_braked) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch word %0d: exp l=%0d r=%0d b=%0d got l=%0d r=%0d b=%0d",
              results_seen, w.left, w.right, w.braked,
              out_left_power, out_right_power, out_braked);
        end
      end
    end
  end

  // directed rows; typed-in values only for trivially readable cases
  drive_row_t rows [ROW_DEPTH];
  int n_rows = 0;

  task automatic add_row(int sc, int tc, bit c = 0, int l = 0, int r = 0, bit b = 0);
    drive_row_t x;
    x.speed = 16'(sc); x.turn = 16'(tc); x.chk = c;
    x.want.left = 16'(l); x.want.right = 16'(r); x.want.braked = b;
    rows[n_rows] = x;
    n_rows++;
  endtask

  initial begin
    power_word_t p;
    foreach (curve[i]) curve[i] = int'((longint'(32 + i) *
      root5((longint'(32 + i) * (32 + i) * (32 + i)) << 30)) / 4);
    reset_mirror();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero in after reset gives zero power, no braking
    add_row(0, 0, 1, 0, 0, 0);
    add_row(32767, 0);          // full forward, rescaled to full power
    add_row(-32768, 0);
    add_row(32767, 32767);
    add_row(-32768, -32768);
    add_row(0, 32767);
    add_row(0, -32768);
    add_row(20, 0, 1, 0, 0, 0); // inside the deadband
    add_row(-40, 0, 1, 0, 0, 0);
    add_row(41, 0);
    for (int k = 0; k < 10; k++) add_row(6000, 100);
    add_row(-6000, 0);          // large drop against high average: braking
    add_row(-32768, 500);       // braking with saturation
    add_row(1, -1);
    add_row(100, 7);
    for (int i = 0; i < n_rows; i++) begin
      p = mix_drive(rows[i].speed, rows[i].turn);
      if (rows[i].chk && p !== rows[i].want) begin
        errors++;
        $display("predictor disagrees on row %0d", i);
      end
      // store the prediction; send_word predicts again after the mirror is reset
      rows[i].want = p;
    end
    reset_mirror();
    // rewind mirror: replay through send_word for the actual traffic
    for (int i = 0; i < n_rows; i++) send_word(rows[i].speed, rows[i].turn);
    wait_drained();

    // extreme register settings
    write_all(0, 0, 32767, 32767, 0);
    idle_free = 1'b1;
    random_phase(300);
    idle_free = 1'b0;
    wait_drained();
    write_all(16384, 32767, 1, 0, 4096);
    random_phase(200);
    wait_drained();
    write_all(32767, 100, 0, 32767, 8191);   // over-range power, zero max speed
    random_phase(200);
    wait_drained();
    write_reg(REG_NONE, 16'h1234);           // unmapped index is ignored
    write_all(3277, 2048, 6472, 1024, 41);
    random_phase(600);
    // receiver stall while sender keeps offering
    hold_off = 1'b1;
    fork
      random_phase(20);
      begin repeat (500) @(posedge clk); hold_off = 1'b0; end
    join
    wait_drained();
    write_all($urandom_range(16384), $urandom_range(32767), $urandom_range(1, 32767),
              $urandom_range(32767), $urandom_range(4096));
    random_phase(630);
    wait_drained();
    if (errors == 0) $display("tb_differential_drive_mixer_with_braking_unit: clean");
    else $display("tb_differential_drive_mixer_with_braking_unit: errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_differential_drive_mixer_with_braking_unit: errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ddm_pkg.sv
rtl/ddm_mul.sv
rtl/ddm_div.sv
rtl/ddm_hist.sv
rtl/differential_drive_mixer_with_braking_unit.sv
tb/tb_differential_drive_mixer_with_braking_unit.sv
